[sv/tmpid_pkg.sv]
`timescale 1ns / 1ps
// tmpid_pkg: shared types, codes and saturating helpers of the three-mode pid step
package tmpid_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_MODE        = 3'd0,
		CFG_GAIN_P      = 3'd1,
		CFG_GAIN_I      = 3'd2,
		CFG_GAIN_D      = 3'd3,
		CFG_GAIN_SQUARE = 3'd4,
		CFG_OUT_MIN     = 3'd5,
		CFG_OUT_MAX     = 3'd6,
		CFG_EPSILON     = 3'd7
	} cfg_idx_t;

	// controller modes; the fourth code keeps the integral and accumulator and drives zero
	localparam logic [1:0] MODE_MOTOR  = 2'd0;
	localparam logic [1:0] MODE_SERVO  = 2'd1;
	localparam logic [1:0] MODE_NONLIN = 2'd2;

	// |error change| * 1000 stays below 2^42
	localparam int DivBits  = 42;
	localparam int DivCntW  = 6;
	localparam logic signed [32:0] RateScale = 33'sd1000;

	// sequencer states, one-hot
	typedef enum logic [17:0] {
		S_IDLE    = 18'h00001,
		S_ERR     = 18'h00002,
		S_MDIFF   = 18'h00004,
		S_DIVINIT = 18'h00008,
		S_DIV     = 18'h00010,
		S_DEREND  = 18'h00020,
		S_MINT    = 18'h00040,
		S_INT     = 18'h00080,
		S_MSQ     = 18'h00100,
		S_SQ      = 18'h00200,
		S_MP      = 18'h00400,
		S_PT      = 18'h00800,
		S_MI      = 18'h01000,
		S_IT      = 18'h02000,
		S_MD      = 18'h04000,
		S_DT      = 18'h08000,
		S_ACC     = 18'h10000,
		S_OUT     = 18'h20000
	} state_t;

	// saturate a 64-bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x[63:31] == '0 || x[63:31] == '1) begin
			r = $signed(x[31:0]);
		end else if (x[63]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

	// 64-bit add that sticks at the rails
	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		logic signed [63:0] r;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			r = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

[sv/three_mode_pid_step.sv]
`timescale 1ns / 1ps
// three_mode_pid_step: pid controller step on one shared multiplier and a radix-2 divider
//
// channel   dir  handshake           word contents (lsb first)
// s_*       in   s_tvalid/s_tready   setpoint[31:0] measured[63:32] elapsed_ms[79:64]
// m_*       out  m_tvalid/m_tready   drive, error_now, derivative_now, integral_now
// cfg_*     in   cfg_we              cfg_index selects register, cfg_data holds value
//
// the derivative goes through the 42-step restoring divider unless elapsed_ms is zero;
// the rest is one 33x33 multiply each for the rate, integral step, square and gain terms,
// each followed by a register
// s_tready is high only while the sequencer idles; the result sits in the output
// register, so the next word is taken while m_tvalid waits on m_tready
// arst_n clears all config registers, previous error, integral and accumulator
module three_mode_pid_step #(
	parameter int FRACTION_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,   // setpoint, measured, elapsed_ms
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // drive, error_now, derivative_now, integral_now
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	// configuration registers
	logic [1:0]         mode_q;
	logic signed [31:0] gain_p_q;
	logic signed [31:0] gain_i_q;
	logic signed [31:0] gain_d_q;
	logic signed [31:0] gain_square_q;
	logic signed [31:0] out_min_q;
	logic signed [31:0] out_max_q;
	logic [30:0]        epsilon_q;

	// controller state kept across items
	logic signed [31:0] prev_err_q;
	logic signed [63:0] integral_q;
	logic signed [63:0] acc_q;

	// per-item working registers
	tmpid_pkg::state_t  state_q;
	logic signed [31:0] sp_q;
	logic signed [31:0] meas_q;
	logic [15:0]        dt_q;
	logic signed [31:0] err_q;
	logic [31:0]        mag_q;
	logic signed [31:0] der_q;
	logic signed [31:0] integ32_q;
	logic signed [31:0] sq_q;
	logic signed [63:0] sum_q;
	logic               neg_q;
	logic [tmpid_pkg::DivBits-1:0] quo_q;   // dividend shifts out, quotient shifts in
	logic [15:0]        rem_q;
	logic [tmpid_pkg::DivCntW-1:0] cnt_q;

	// shared multiplier
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] prod_q;
	logic signed [65:0] prod_sh;

	// output register
	logic               m_tvalid_q;
	logic [127:0]       m_tdata_q;

	// combinational helpers
	logic signed [32:0] err_wide;
	logic signed [65:0] prod_mag;
	logic [16:0]        trial;
	logic signed [63:0] drive_c;
	logic [tmpid_pkg::DivBits-1:0] neg_lim;
	logic [tmpid_pkg::DivBits-1:0] pos_lim;

	assign s_tready = (state_q == tmpid_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign err_wide = {sp_q[31], sp_q} - {meas_q[31], meas_q};
	assign prod_sh  = prod_q >>> FRACTION_BITS;   // floor rescale
	assign prod_mag = prod_q[65] ? -prod_q : prod_q;
	assign trial    = {rem_q, quo_q[tmpid_pkg::DivBits-1]};
	assign pos_lim  = tmpid_pkg::DivBits'(33'h0_7FFF_FFFF);
	assign neg_lim  = tmpid_pkg::DivBits'(33'h0_8000_0000);

	// operand select of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			tmpid_pkg::S_MDIFF: begin
				mul_a = {err_q[31], err_q} - {prev_err_q[31], prev_err_q};
				mul_b = tmpid_pkg::RateScale;
			end
			tmpid_pkg::S_MINT: begin
				mul_a = {err_q[31], err_q};
				mul_b = {17'd0, dt_q};
			end
			tmpid_pkg::S_MSQ: begin
				mul_a = {err_q[31], err_q};
				mul_b = {1'b0, mag_q};
			end
			tmpid_pkg::S_MP: begin
				if (mode_q == tmpid_pkg::MODE_NONLIN) begin
					mul_a = {gain_square_q[31], gain_square_q};
					mul_b = {sq_q[31], sq_q};
				end else begin
					mul_a = {gain_p_q[31], gain_p_q};
					mul_b = {err_q[31], err_q};
				end
			end
			tmpid_pkg::S_MI: begin
				mul_a = {gain_i_q[31], gain_i_q};
				mul_b = {integ32_q[31], integ32_q};
			end
			tmpid_pkg::S_MD: begin
				mul_a = {gain_d_q[31], gain_d_q};
				mul_b = {der_q[31], der_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// clamp: limit to out_max first, then raise to out_min; the fourth mode code drives zero
	always_comb begin
		drive_c = acc_q;
		if (drive_c > 64'(out_max_q)) begin
			drive_c = 64'(out_max_q);
		end
		if (drive_c < 64'(out_min_q)) begin
			drive_c = 64'(out_min_q);
		end
		if (mode_q != tmpid_pkg::MODE_MOTOR && mode_q != tmpid_pkg::MODE_SERVO
				&& mode_q != tmpid_pkg::MODE_NONLIN) begin
			drive_c = '0;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= '0;
			gain_p_q      <= '0;
			gain_i_q      <= '0;
			gain_d_q      <= '0;
			gain_square_q <= '0;
			out_min_q     <= '0;
			out_max_q     <= '0;
			epsilon_q     <= '0;
		end else if (cfg_we) begin
			unique case (tmpid_pkg::cfg_idx_t'(cfg_index))
				tmpid_pkg::CFG_MODE:        mode_q        <= cfg_data[1:0];
				tmpid_pkg::CFG_GAIN_P:      gain_p_q      <= $signed(cfg_data);
				tmpid_pkg::CFG_GAIN_I:      gain_i_q      <= $signed(cfg_data);
				tmpid_pkg::CFG_GAIN_D:      gain_d_q      <= $signed(cfg_data);
				tmpid_pkg::CFG_GAIN_SQUARE: gain_square_q <= $signed(cfg_data);
				tmpid_pkg::CFG_OUT_MIN:     out_min_q     <= $signed(cfg_data);
				tmpid_pkg::CFG_OUT_MAX:     out_max_q     <= $signed(cfg_data);
				tmpid_pkg::CFG_EPSILON:     epsilon_q     <= cfg_data[30:0];
				default:                    mode_q        <= mode_q;
			endcase
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			tmpid_pkg::S_IDLE: begin
				sp_q   <= $signed(s_tdata[31:0]);
				meas_q <= $signed(s_tdata[63:32]);
				dt_q   <= s_tdata[79:64];
			end
			tmpid_pkg::S_ERR: begin
				err_q <= tmpid_pkg::sat32(64'(err_wide));
			end
			tmpid_pkg::S_MDIFF: begin
				mag_q <= err_q[31] ? (~err_q + 32'd1) : err_q;
			end
			tmpid_pkg::S_DIVINIT: begin
				neg_q <= prod_q[65];
				quo_q <= prod_mag[tmpid_pkg::DivBits-1:0];
				rem_q <= '0;
				cnt_q <= '0;
				if (dt_q == '0) begin
					der_q <= '0;
				end
			end
			tmpid_pkg::S_DIV: begin
				// one restoring step per cycle
				if (trial >= {1'b0, dt_q}) begin
					rem_q <= 16'(trial - {1'b0, dt_q});
					quo_q <= {quo_q[tmpid_pkg::DivBits-2:0], 1'b1};
				end else begin
					rem_q <= trial[15:0];
					quo_q <= {quo_q[tmpid_pkg::DivBits-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			tmpid_pkg::S_DEREND: begin
				// truncated quotient with sign, then saturation
				if (neg_q) begin
					der_q <= (quo_q > neg_lim) ? 32'sh8000_0000 : -$signed(quo_q[31:0]);
				end else begin
					der_q <= (quo_q > pos_lim) ? 32'sh7FFF_FFFF : $signed(quo_q[31:0]);
				end
			end
			tmpid_pkg::S_MSQ: begin
				integ32_q <= tmpid_pkg::sat32(integral_q);
			end
			tmpid_pkg::S_SQ: begin
				sq_q <= tmpid_pkg::sat32(prod_sh[63:0]);
			end
			tmpid_pkg::S_PT: begin
				sum_q <= prod_sh[63:0];
			end
			tmpid_pkg::S_IT, tmpid_pkg::S_DT: begin
				sum_q <= tmpid_pkg::sat_add64(sum_q, prod_sh[63:0]);
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	// sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tmpid_pkg::S_IDLE;
			prev_err_q <= '0;
			integral_q <= '0;
			acc_q      <= '0;
		end else begin
			unique case (state_q)
				tmpid_pkg::S_IDLE: begin
					if (s_tvalid) begin
						state_q <= tmpid_pkg::S_ERR;
					end
				end
				tmpid_pkg::S_ERR:   state_q <= tmpid_pkg::S_MDIFF;
				tmpid_pkg::S_MDIFF: begin
					prev_err_q <= err_q;
					state_q    <= tmpid_pkg::S_DIVINIT;
				end
				tmpid_pkg::S_DIVINIT: begin
					// zero elapsed time: no division, derivative is zero
					state_q <= (dt_q == '0) ? tmpid_pkg::S_MINT : tmpid_pkg::S_DIV;
				end
				tmpid_pkg::S_DIV: begin
					if (cnt_q == tmpid_pkg::DivCntW'(tmpid_pkg::DivBits - 1)) begin
						state_q <= tmpid_pkg::S_DEREND;
					end
				end
				tmpid_pkg::S_DEREND: state_q <= tmpid_pkg::S_MINT;
				tmpid_pkg::S_MINT:   state_q <= tmpid_pkg::S_INT;
				tmpid_pkg::S_INT: begin
					// motor mode integrates only outside the dead band
					if (mode_q == tmpid_pkg::MODE_MOTOR && mag_q >= {1'b0, epsilon_q}) begin
						integral_q <= tmpid_pkg::sat_add64(integral_q, prod_q[63:0]);
					end
					state_q <= tmpid_pkg::S_MSQ;
				end
				tmpid_pkg::S_MSQ: state_q <= tmpid_pkg::S_SQ;
				tmpid_pkg::S_SQ:  state_q <= tmpid_pkg::S_MP;
				tmpid_pkg::S_MP:  state_q <= tmpid_pkg::S_PT;
				tmpid_pkg::S_PT:  state_q <= tmpid_pkg::S_MI;
				tmpid_pkg::S_MI:  state_q <= tmpid_pkg::S_IT;
				tmpid_pkg::S_IT:  state_q <= tmpid_pkg::S_MD;
				tmpid_pkg::S_MD:  state_q <= tmpid_pkg::S_DT;
				tmpid_pkg::S_DT:  state_q <= tmpid_pkg::S_ACC;
				tmpid_pkg::S_ACC: begin
					case (mode_q)
						tmpid_pkg::MODE_MOTOR: acc_q <= tmpid_pkg::sat_add64(acc_q, sum_q);
						tmpid_pkg::MODE_SERVO, tmpid_pkg::MODE_NONLIN: acc_q <= sum_q;
						default: acc_q <= acc_q;
					endcase
					state_q <= tmpid_pkg::S_OUT;
				end
				tmpid_pkg::S_OUT: begin
					// hold here until the output register is free
					if (!m_tvalid_q || m_tready) begin
						state_q <= tmpid_pkg::S_IDLE;
					end
				end
				default: state_q <= tmpid_pkg::S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == tmpid_pkg::S_OUT && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tmpid_pkg::S_OUT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {integ32_q, der_q, err_q, drive_c[31:0]};
		end
	end

endmodule
